// File: hw/rtl/mm256_pkg.sv
// Shared types and constants for the 256-bit Montgomery multiplier.
`timescale 1ns / 1ps
package mm256_pkg;

  localparam int LIMB_BITS  = 64;
  localparam int LIMB_COUNT = 4;
  localparam int OPND_BITS  = LIMB_BITS * LIMB_COUNT;
  localparam int ACC_BITS   = OPND_BITS + 1;
  localparam int PROD_BITS  = 2 * LIMB_BITS;
  localparam int SUM_BITS   = OPND_BITS + LIMB_BITS + 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int ROUND_LAT  = 8;
  localparam int FINAL_LAT  = 2;
  localparam int LATENCY    = LIMB_COUNT * ROUND_LAT + FINAL_LAT;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_0   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_1   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_2   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_3   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEG_INV = 3'd4;

  typedef struct packed {
    logic [LIMB_BITS-1:0] x_word_0;
    logic [LIMB_BITS-1:0] x_word_1;
    logic [LIMB_BITS-1:0] x_word_2;
    logic [LIMB_BITS-1:0] x_word_3;
    logic [LIMB_BITS-1:0] y_word_0;
    logic [LIMB_BITS-1:0] y_word_1;
    logic [LIMB_BITS-1:0] y_word_2;
    logic [LIMB_BITS-1:0] y_word_3;
  } in_req_t;

  typedef struct packed {
    logic [LIMB_BITS-1:0] prod_word_0;
    logic [LIMB_BITS-1:0] prod_word_1;
    logic [LIMB_BITS-1:0] prod_word_2;
    logic [LIMB_BITS-1:0] prod_word_3;
  } out_res_t;

endpackage

// File: hw/rtl/mm256_mul64.sv
// Two-stage 64x64 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module mm256_mul64
  import mm256_pkg::*;
(
  input  logic                 clk,
  input  logic [LIMB_BITS-1:0] a_in,
  input  logic [LIMB_BITS-1:0] b_in,
  output logic [PROD_BITS-1:0] prod_out
);

  localparam int HALF = LIMB_BITS / 2;

  logic [LIMB_BITS-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [PROD_BITS-1:0] prod_r;

  // Form partial products
  always_ff @(posedge clk) begin
    pp00_r <= a_in[HALF-1:0] * b_in[HALF-1:0];
    pp01_r <= a_in[HALF-1:0] * b_in[LIMB_BITS-1:HALF];
    pp10_r <= a_in[LIMB_BITS-1:HALF] * b_in[HALF-1:0];
    pp11_r <= a_in[LIMB_BITS-1:HALF] * b_in[LIMB_BITS-1:HALF];
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    prod_r <= {{LIMB_BITS{1'b0}}, pp00_r}
            + {{HALF{1'b0}}, pp01_r, {HALF{1'b0}}}
            + {{HALF{1'b0}}, pp10_r, {HALF{1'b0}}}
            + {pp11_r, {LIMB_BITS{1'b0}}};
  end

  assign prod_out = prod_r;

endmodule

// File: hw/rtl/mm256_round.sv
// One CIOS round: add x_i*y, form u, add u*p and shift down one limb.
`timescale 1ns / 1ps
module mm256_round
  import mm256_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  input  logic [LIMB_BITS-1:0] xi_in,
  input  logic [OPND_BITS-1:0] x_in,
  input  logic [OPND_BITS-1:0] y_in,
  input  logic [ACC_BITS-1:0]  acc_in,
  input  logic [OPND_BITS-1:0] mod_in,
  input  logic [LIMB_BITS-1:0] ninv_in,
  output logic                 valid_out,
  output logic [OPND_BITS-1:0] x_out,
  output logic [OPND_BITS-1:0] y_out,
  output logic [ACC_BITS-1:0]  acc_out
);

  logic [ROUND_LAT-1:0]  vld_r;
  logic [OPND_BITS-1:0]  x_d_r [ROUND_LAT];
  logic [OPND_BITS-1:0]  y_d_r [ROUND_LAT];
  logic [ACC_BITS-1:0]   acc_d_r [2];
  logic [SUM_BITS-1:0]   s_r;
  logic [SUM_BITS-1:0]   s_d_r [4];
  logic [ACC_BITS-1:0]   acc_r;
  logic [PROD_BITS-1:0]  xy_prod [LIMB_COUNT];
  logic [PROD_BITS-1:0]  up_prod [LIMB_COUNT];
  logic [PROD_BITS-1:0]  u_prod;
  logic [SUM_BITS-1:0]   s_nxt;
  logic [SUM_BITS:0]     t_nxt;

  // Multiply x_i by each limb of y, and u by each limb of p
  for (genvar j = 0; j < LIMB_COUNT; j++) begin : g_mul
    mm256_mul64 u_xy (
      .clk      (clk),
      .a_in     (xi_in),
      .b_in     (y_in[j*LIMB_BITS +: LIMB_BITS]),
      .prod_out (xy_prod[j])
    );
    mm256_mul64 u_up (
      .clk      (clk),
      .a_in     (u_prod[LIMB_BITS-1:0]),
      .b_in     (mod_in[j*LIMB_BITS +: LIMB_BITS]),
      .prod_out (up_prod[j])
    );
  end

  // u = low limb of the sum times m'
  mm256_mul64 u_uq (
    .clk      (clk),
    .a_in     (s_r[LIMB_BITS-1:0]),
    .b_in     (ninv_in),
    .prod_out (u_prod)
  );

  // Accumulate x_i*y into the running value
  always_comb begin
    s_nxt = {{(SUM_BITS-ACC_BITS){1'b0}}, acc_d_r[1]};
    for (int j = 0; j < LIMB_COUNT; j++) begin
      s_nxt = s_nxt + (SUM_BITS'(xy_prod[j]) << (j * LIMB_BITS));
    end
  end

  // Add u*p and drop the low limb
  always_comb begin
    t_nxt = {1'b0, s_d_r[3]};
    for (int j = 0; j < LIMB_COUNT; j++) begin
      t_nxt = t_nxt + ((SUM_BITS+1)'(up_prod[j]) << (j * LIMB_BITS));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ROUND_LAT-2:0], valid_in};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    x_d_r[0]   <= x_in;
    y_d_r[0]   <= y_in;
    for (int k = 1; k < ROUND_LAT; k++) begin
      x_d_r[k] <= x_d_r[k-1];
      y_d_r[k] <= y_d_r[k-1];
    end
    acc_d_r[0] <= acc_in;
    acc_d_r[1] <= acc_d_r[0];
    s_r        <= s_nxt;
    s_d_r[0]   <= s_r;
    for (int k = 1; k < 4; k++) begin
      s_d_r[k] <= s_d_r[k-1];
    end
    acc_r      <= t_nxt[LIMB_BITS +: ACC_BITS];
  end

  assign valid_out = vld_r[ROUND_LAT-1];
  assign x_out     = x_d_r[ROUND_LAT-1];
  assign y_out     = y_d_r[ROUND_LAT-1];
  assign acc_out   = acc_r;

endmodule

// File: hw/rtl/mm256_final.sv
// Final quasi-reduction: keep the value when it is at most p, else subtract p.
`timescale 1ns / 1ps
module mm256_final
  import mm256_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  input  logic [ACC_BITS-1:0]  acc_in,
  input  logic [OPND_BITS-1:0] mod_in,
  output logic                 valid_out,
  output logic [OPND_BITS-1:0] res_out
);

  logic [1:0]           vld_r;
  logic [OPND_BITS-1:0] acc_r;
  logic [OPND_BITS-1:0] diff_r;
  logic                 keep_r;
  logic [OPND_BITS-1:0] res_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], valid_in};
    end
  end

  // Compare and subtract, then select
  always_ff @(posedge clk) begin
    acc_r  <= acc_in[OPND_BITS-1:0];
    diff_r <= acc_in[OPND_BITS-1:0] - mod_in;
    keep_r <= (acc_in[OPND_BITS-1:0] <= mod_in) && !acc_in[OPND_BITS];
    res_r  <= keep_r ? acc_r : diff_r;
  end

  assign valid_out = vld_r[1];
  assign res_out   = res_r;

endmodule

// File: hw/rtl/montgomery_multiplier_256.sv
// Top level of the pipelined 256-bit Montgomery multiplier.
//
// Usage: raise start with the operands on in_req; the request is taken at
// every rising edge where start is high and busy is low. busy never rises,
// so one request can enter in every cycle.
// Each request gives one result on out_res, marked by out_valid for one
// cycle. The pipeline holds four rounds of eight stages (x_i*y, u = A0*m',
// u*p, each on two-stage 64x64 multipliers) and two stages of final
// reduction. Results leave in request order.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// The modulus limbs and m' are written through cfg_we, cfg_idx and cfg_wdata;
// the user must write them only while no request is in flight, which the block
// does not enforce. Unknown indexes are ignored. Synchronous reset clears all
// valid bits and the configuration registers; requests in flight at reset are dropped.
`timescale 1ns / 1ps
module montgomery_multiplier_256
  import mm256_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  in_req_t                 in_req,
  output logic                    out_valid,
  output out_res_t                out_res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [LIMB_BITS-1:0]    cfg_wdata
);

  logic [OPND_BITS-1:0] mod_r;
  logic [LIMB_BITS-1:0] ninv_r;
  logic                 vld_w [LIMB_COUNT+1];
  logic [OPND_BITS-1:0] x_w   [LIMB_COUNT+1];
  logic [OPND_BITS-1:0] y_w   [LIMB_COUNT+1];
  logic [ACC_BITS-1:0]  acc_w [LIMB_COUNT+1];
  logic [OPND_BITS-1:0] res;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= '0;
      ninv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MOD_0:   mod_r[0*LIMB_BITS +: LIMB_BITS] <= cfg_wdata;
        CFG_MOD_1:   mod_r[1*LIMB_BITS +: LIMB_BITS] <= cfg_wdata;
        CFG_MOD_2:   mod_r[2*LIMB_BITS +: LIMB_BITS] <= cfg_wdata;
        CFG_MOD_3:   mod_r[3*LIMB_BITS +: LIMB_BITS] <= cfg_wdata;
        CFG_NEG_INV: ninv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Enter the pipeline with the accumulator at p
  assign vld_w[0] = start && !busy;
  assign x_w[0]   = {in_req.x_word_3, in_req.x_word_2, in_req.x_word_1, in_req.x_word_0};
  assign y_w[0]   = {in_req.y_word_3, in_req.y_word_2, in_req.y_word_1, in_req.y_word_0};
  assign acc_w[0] = {1'b0, mod_r};

  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_round
    mm256_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (vld_w[i]),
      .xi_in     (x_w[i][i*LIMB_BITS +: LIMB_BITS]),
      .x_in      (x_w[i]),
      .y_in      (y_w[i]),
      .acc_in    (acc_w[i]),
      .mod_in    (mod_r),
      .ninv_in   (ninv_r),
      .valid_out (vld_w[i+1]),
      .x_out     (x_w[i+1]),
      .y_out     (y_w[i+1]),
      .acc_out   (acc_w[i+1])
    );
  end

  mm256_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (vld_w[LIMB_COUNT]),
    .acc_in    (acc_w[LIMB_COUNT]),
    .mod_in    (mod_r),
    .valid_out (out_valid),
    .res_out   (res)
  );

  assign out_res.prod_word_0 = res[0*LIMB_BITS +: LIMB_BITS];
  assign out_res.prod_word_1 = res[1*LIMB_BITS +: LIMB_BITS];
  assign out_res.prod_word_2 = res[2*LIMB_BITS +: LIMB_BITS];
  assign out_res.prod_word_3 = res[3*LIMB_BITS +: LIMB_BITS];

`ifndef SYNTH
  a_out_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a request");
  a_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n, LATENCY))
    else $error("result from a request taken during reset");
  a_final_fed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_w[LIMB_COUNT], FINAL_LAT))
    else $error("reduction stage out of step with rounds");
`endif

endmodule

// File: tb/sv/tb.sv
// Testbench for the 256-bit Montgomery multiplier: predicts each product and checks it.
`timescale 1ns / 1ps
module tb;
  import mm256_pkg::*;

  typedef logic [LIMB_BITS-1:0] limb_t;
  typedef logic [OPND_BITS-1:0] wide_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_req_t         in_req;
  logic            out_valid;
  out_res_t        out_res;
  logic            cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [LIMB_BITS-1:0]    cfg_wdata;

  montgomery_multiplier_256 uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow configuration
  limb_t     mod_limb [LIMB_COUNT];
  limb_t     minv;
  out_res_t  prod_q [$];
  int        errors;
  longint    cycles;
  int        gap_bias;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("montgomery_multiplier_256: mismatch");
      $finish;
    end
  end

  task automatic report(input string what, input limb_t got, input limb_t want);
    $display("ERROR %s got %h want %h", what, got, want);
    errors++;
  endtask

  // Compute the quasi-reduced Montgomery product for the current setting
  function automatic out_res_t mont_product(input in_req_t r);
    limb_t x [LIMB_COUNT];
    limb_t y [LIMB_COUNT];
    limb_t acc [LIMB_COUNT];
    logic  hw;
    logic [127:0] t;
    limb_t c, c2, a0, u;
    logic [65:0] top;
    wide_t pv, av, sv;
    logic [256:0] diff;
    logic borrow, sel;
    out_res_t o;
    x = '{r.x_word_0, r.x_word_1, r.x_word_2, r.x_word_3};
    y = '{r.y_word_0, r.y_word_1, r.y_word_2, r.y_word_3};
    for (int i = 0; i < LIMB_COUNT; i++) acc[i] = mod_limb[i];
    hw = 1'b0;
    for (int i = 0; i < LIMB_COUNT; i++) begin
      t = x[i] * y[0] + acc[0];
      c = t[127:64]; a0 = t[63:0];
      u = a0 * minv;
      t = u * mod_limb[0] + a0;
      c2 = t[127:64];
      for (int j = 1; j < LIMB_COUNT; j++) begin
        t = x[i] * y[j] + acc[j] + c;
        c = t[127:64]; acc[j] = t[63:0];
      end
      for (int j = 1; j < LIMB_COUNT; j++) begin
        t = u * mod_limb[j] + acc[j] + c2;
        c2 = t[127:64]; acc[j] = t[63:0];
      end
      for (int j = 1; j < LIMB_COUNT; j++) acc[j-1] = acc[j];
      top = hw + c + c2;
      acc[LIMB_COUNT-1] = top[63:0];
      hw = top[64];
    end
    pv = {mod_limb[3], mod_limb[2], mod_limb[1], mod_limb[0]};
    av = {acc[3], acc[2], acc[1], acc[0]};
    diff = {1'b0, av} - {1'b0, pv} - 257'd1;
    borrow = diff[256];
    sel = borrow & ~hw;
    sv = sel ? diff[255:0] + pv + 256'd1 : diff[255:0] + 256'd1;
    o.prod_word_0 = sv[63:0];
    o.prod_word_1 = sv[127:64];
    o.prod_word_2 = sv[191:128];
    o.prod_word_3 = sv[255:192];
    return o;
  endfunction

  // Compare each product with the oldest expectation
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (prod_q.size() == 0) begin
        report("product with nothing expected", out_res.prod_word_0, 'x);
      end else begin
        want = prod_q.pop_front();
        if (out_res.prod_word_0 !== want.prod_word_0)
          report("prod_word_0", out_res.prod_word_0, want.prod_word_0);
        if (out_res.prod_word_1 !== want.prod_word_1)
          report("prod_word_1", out_res.prod_word_1, want.prod_word_1);
        if (out_res.prod_word_2 !== want.prod_word_2)
          report("prod_word_2", out_res.prod_word_2, want.prod_word_2);
        if (out_res.prod_word_3 !== want.prod_word_3)
          report("prod_word_3", out_res.prod_word_3, want.prod_word_3);
      end
    end
  end

  // Send one request, hold start until it is taken
  task automatic send_req(input in_req_t r);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    prod_q.push_back(mont_product(r));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 99) < gap_bias) begin
      start <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk);
    end
  endtask

  // Drain, then write one register
  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input limb_t val);
    start <= 1'b0;
    while (prod_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MOD_0: mod_limb[0] = val;
      CFG_MOD_1: mod_limb[1] = val;
      CFG_MOD_2: mod_limb[2] = val;
      CFG_MOD_3: mod_limb[3] = val;
      CFG_NEG_INV: minv = val;
      default: ;
    endcase
  endtask

  function automatic limb_t neg_inv(input limb_t p0);
    limb_t v;
    v = 64'd1;
    for (int k = 0; k < 6; k++) v = v * (64'd2 - p0 * v);
    return -v;
  endfunction

  task automatic set_modulus(input wide_t p);
    write_cfg(CFG_MOD_0, p[63:0]);
    write_cfg(CFG_MOD_1, p[127:64]);
    write_cfg(CFG_MOD_2, p[191:128]);
    write_cfg(CFG_MOD_3, p[255:192]);
    write_cfg(CFG_NEG_INV, neg_inv(p[63:0]));
  endtask

  function automatic limb_t rand_limb();
    return {$urandom(), $urandom()};
  endfunction

  function automatic limb_t pick_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      default: return rand_limb();
    endcase
  endfunction

  // Operand from 1 up to the modulus most of the time, raw bits otherwise
  function automatic wide_t rand_opnd();
    wide_t p, v;
    p = {mod_limb[3], mod_limb[2], mod_limb[1], mod_limb[0]};
    v = {pick_limb(), pick_limb(), pick_limb(), pick_limb()};
    if ($urandom_range(0, 9) < 8 && p > 1) v = (v % p) + 1;
    return v;
  endfunction

  function automatic in_req_t make_req(input wide_t a, input wide_t b);
    in_req_t r;
    r = {b, a};
    r.x_word_0 = a[63:0];   r.x_word_1 = a[127:64];
    r.x_word_2 = a[191:128]; r.x_word_3 = a[255:192];
    r.y_word_0 = b[63:0];   r.y_word_1 = b[127:64];
    r.y_word_2 = b[191:128]; r.y_word_3 = b[255:192];
    return r;
  endfunction

  // Registers at reset value: datapath runs with zero modulus
  task automatic test_reset_config();
    send_req(make_req('0, '0));
    send_req(make_req('1, '1));
    send_req(make_req({4{64'h0123456789abcdef}}, {4{64'hfedcba9876543210}}));
  endtask

  // Operand extremes around a real prime
  task automatic test_extremes();
    wide_t p;
    p = {mod_limb[3], mod_limb[2], mod_limb[1], mod_limb[0]};
    send_req(make_req(256'd1, 256'd1));
    send_req(make_req(p, p));
    send_req(make_req(p, 256'd1));
    send_req(make_req(p - 1, p - 1));
    send_req(make_req(256'd1, p - 1));
    send_req(make_req('1, '1));
    send_req(make_req('0, '1));
    send_req(make_req(p + 1, p + 2));
    send_req(make_req({4{64'haaaaaaaaaaaaaaaa}}, {4{64'h5555555555555555}}));
    send_req(make_req({4{64'h5555555555555555}}, {4{64'haaaaaaaaaaaaaaaa}}));
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) gap_bias = $urandom_range(0, 3) * 25;
      idle_gap();
      send_req(make_req(rand_opnd(), rand_opnd()));
    end
  endtask

  // Inconsistent m' and two indexes outside the register map
  task automatic test_bad_config();
    write_cfg(CFG_NEG_INV, rand_limb());
    write_cfg(3'd7, rand_limb());
    write_cfg(3'd5, '1);
    test_random(60);
  endtask

  initial begin
    wide_t p256, p25519, pmax;
    errors = 0; cycles = 0; gap_bias = 0;
    for (int i = 0; i < LIMB_COUNT; i++) mod_limb[i] = '0;
    minv = '0;
    rst_n = 1'b0; start = 1'b0; in_req = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    p256   = 256'hffffffff00000001000000000000000000000000ffffffffffffffffffffffff;
    p25519 = 256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
    pmax   = 256'hffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffff43;
    test_reset_config();
    set_modulus(p256);
    test_extremes();
    test_random(700);
    set_modulus(p25519);
    test_extremes();
    test_random(450);
    set_modulus(pmax);
    test_extremes();
    test_random(450);
    test_bad_config();
    set_modulus(256'd3);
    test_random(40);
    start <= 1'b0;
    while (prod_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0)
      $display("montgomery_multiplier_256: match");
    else
      $display("montgomery_multiplier_256: mismatch");
    $finish;
  end

endmodule
